// ----- src/mosc_pkg.sv -----
// ----------------------------------------------------------------------------
// mosc_pkg
// Shared types, constants and helpers for the monitor overlap select block.
// ----------------------------------------------------------------------------
package mosc_pkg;

	localparam int MAX_MONITORS = 16;
	localparam int CNT_W = $clog2(MAX_MONITORS + 1);
	localparam int IDX_W = (MAX_MONITORS > 1) ? $clog2(MAX_MONITORS) : 1;

	localparam logic [1:0] CMD_WINDOW  = 2'd0;
	localparam logic [1:0] CMD_SECOND  = 2'd1;
	localparam logic [1:0] CMD_MONITOR = 2'd2;
	localparam logic [1:0] CMD_UNUSED  = 2'd3;

	typedef logic signed [15:0] coord_t;
	typedef logic signed [17:0] pos_t;

	typedef struct packed {
		coord_t xl;
		coord_t yl;
		coord_t xh;
		coord_t yh;
	} rect_t;

	// clipped extent of window span [wlo,whi) against monitor span [mlo,mhi), floored at 0
	function automatic logic [15:0] overlap_len(coord_t wlo, coord_t whi, coord_t mlo,
			coord_t mhi);
		logic signed [18:0] len;
		len = {{3{whi[15]}}, whi} - {{3{wlo[15]}}, wlo};
		if (wlo < mlo)
			len = len - ({{3{mlo[15]}}, mlo} - {{3{wlo[15]}}, wlo});
		if (whi > mhi)
			len = len - ({{3{whi[15]}}, whi} - {{3{mhi[15]}}, mhi});
		return len[18] ? 16'd0 : len[15:0];
	endfunction

	function automatic pos_t ext18(coord_t v);
		return {{2{v[15]}}, v};
	endfunction

	// low edge clamps first, high edge check overrides it
	function automatic pos_t clamp_pos(coord_t lo, coord_t hi, coord_t mlo, coord_t mhi);
		pos_t p;
		p = ext18(lo);
		if (lo < mlo)
			p = ext18(mlo);
		if (hi > mhi)
			p = ext18(mhi) - ext18(hi) + ext18(lo);
		return p;
	endfunction

endpackage

// ----- src/monitor_overlap_select_clamp_top.sv -----
// ----------------------------------------------------------------------------
// monitor_overlap_select_clamp_top
// Picks the monitor with the largest overlap against a window and emits its
// rect, or a position clamped into it, on the word marked final.
// ----------------------------------------------------------------------------
// Path: an accepted word passes the input register, the area register and the result register to out_valid.
// Throughput: one word per cycle while no result is held; s1 does clip and 16x16 multiply, s2 does the
//   compare against the running best and the clamp.
// All stages advance together; a held result stalls the pipe and in_ready.
// Reset: asynchronous, clears the pipe valids, out_valid and all query state.
module monitor_overlap_select_clamp_top (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [1:0]            cmd,
	input  mosc_pkg::coord_t      x_low,
	input  mosc_pkg::coord_t      y_low,
	input  mosc_pkg::coord_t      x_high,
	input  mosc_pkg::coord_t      y_high,
	input  logic                  final_monitor,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  none_found,
	output logic                  position_mode,
	output logic [3:0]            chosen_index,
	output logic [31:0]           chosen_area,
	output mosc_pkg::coord_t      mon_left,
	output mosc_pkg::coord_t      mon_top,
	output mosc_pkg::coord_t      mon_right,
	output mosc_pkg::coord_t      mon_bottom,
	output mosc_pkg::pos_t        pos_x,
	output mosc_pkg::pos_t        pos_y
);
	import mosc_pkg::*;

	logic              en;
	logic              acc;
	rect_t             in_rect;

	rect_t             window_q;

	logic              vld_s1;
	logic [1:0]        cmd_s1;
	rect_t             rect_s1;
	logic              fin_s1;

	logic              vld_s2;
	logic [1:0]        cmd_s2;
	rect_t             rect_s2;
	logic              fin_s2;
	logic [31:0]       area_s2;

	rect_t             second_q;
	logic              want_pos_q;
	logic [CNT_W-1:0]  seen_q;
	logic [31:0]       best_area_q;
	logic [IDX_W-1:0]  best_idx_q;
	rect_t             best_rect_q;

	rect_t             n_second;
	logic              n_want;
	logic [CNT_W-1:0]  n_seen;
	logic [31:0]       n_best_area;
	logic [IDX_W-1:0]  n_best_idx;
	rect_t             n_best_rect;
	logic [IDX_W-1:0]  mon_idx;
	logic              emit;
	logic [15:0]       ov_w;
	logic [15:0]       ov_h;
	logic [IDX_W+3:0]  idx_ext;

	assign en       = !out_valid || out_ready;
	assign in_ready = en;
	assign acc      = in_valid && en;
	assign in_rect  = '{xl: x_low, yl: y_low, xh: x_high, yh: y_high};

	// window is captured on accept so s1 sees it for the very next monitor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= '0;
		end else if (acc && cmd == CMD_WINDOW) begin
			window_q <= in_rect;
		end
	end

	// stage 1: input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			cmd_s1  <= cmd;
			rect_s1 <= in_rect;
			fin_s1  <= final_monitor;
		end
	end

	assign ov_w = overlap_len(window_q.xl, window_q.xh, rect_s1.xl, rect_s1.xh);
	assign ov_h = overlap_len(window_q.yl, window_q.yh, rect_s1.yl, rect_s1.yh);

	// stage 2: area register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en && vld_s1) begin
			cmd_s2  <= cmd_s1;
			rect_s2 <= rect_s1;
			fin_s2  <= fin_s1;
			area_s2 <= 32'(ov_w) * 32'(ov_h);
		end
	end

	assign mon_idx = (seen_q < CNT_W'(MAX_MONITORS - 1)) ? seen_q[IDX_W-1:0]
		: IDX_W'(MAX_MONITORS - 1);

	always_comb begin
		n_second    = second_q;
		n_want      = want_pos_q;
		n_seen      = seen_q;
		n_best_area = best_area_q;
		n_best_idx  = best_idx_q;
		n_best_rect = best_rect_q;
		emit        = 1'b0;
		if (vld_s2) begin
			emit = fin_s2;
			case (cmd_s2)
				CMD_WINDOW: begin
					n_want      = 1'b0;
					n_seen      = '0;
					n_best_area = '0;
					n_best_idx  = '0;
					n_best_rect = '0;
				end
				CMD_SECOND: begin
					n_second = rect_s2;
					n_want   = 1'b1;
				end
				CMD_MONITOR: begin
					if (seen_q == '0 || area_s2 > best_area_q) begin
						n_best_area = area_s2;
						n_best_idx  = mon_idx;
						n_best_rect = rect_s2;
					end
					if (seen_q < CNT_W'(MAX_MONITORS))
						n_seen = seen_q + CNT_W'(1);
				end
				default: begin
					emit = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			second_q    <= '0;
			want_pos_q  <= 1'b0;
			seen_q      <= '0;
			best_area_q <= '0;
			best_idx_q  <= '0;
			best_rect_q <= '0;
		end else if (en) begin
			second_q    <= n_second;
			want_pos_q  <= n_want;
			seen_q      <= n_seen;
			best_area_q <= n_best_area;
			best_idx_q  <= n_best_idx;
			best_rect_q <= n_best_rect;
		end
	end

	assign idx_ext = {4'd0, n_best_idx};

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (en && emit) begin
			position_mode <= n_want;
			if (n_seen == '0) begin
				none_found   <= 1'b1;
				chosen_index <= '0;
				chosen_area  <= '0;
				mon_left     <= '0;
				mon_top      <= '0;
				mon_right    <= '0;
				mon_bottom   <= '0;
				pos_x        <= '0;
				pos_y        <= '0;
			end else begin
				none_found   <= 1'b0;
				chosen_index <= idx_ext[3:0];
				chosen_area  <= n_best_area;
				mon_left     <= n_best_rect.xl;
				mon_top      <= n_best_rect.yl;
				mon_right    <= n_best_rect.xh;
				mon_bottom   <= n_best_rect.yh;
				pos_x        <= clamp_pos(n_second.xl, n_second.xh, n_best_rect.xl,
					n_best_rect.xh);
				pos_y        <= clamp_pos(n_second.yl, n_second.yh, n_best_rect.yl,
					n_best_rect.yh);
			end
		end
	end

	a_seen_bound: assert property (@(posedge clk) disable iff (!arst_n)
		seen_q <= CNT_W'(MAX_MONITORS))
		else $error("monitor count beyond limit");

	a_empty_best: assert property (@(posedge clk) disable iff (!arst_n)
		seen_q == '0 |-> best_area_q == '0 && best_idx_q == '0)
		else $error("best kept with no monitor seen");

	a_window_clears: assert property (@(posedge clk) disable iff (!arst_n)
		en && vld_s2 && cmd_s2 == CMD_WINDOW |=> seen_q == '0 && !want_pos_q)
		else $error("query start did not clear state");

	a_none_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && none_found |-> chosen_area == '0 && pos_x == '0 && pos_y == '0)
		else $error("empty result carries data");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(seen_q) && $stable(best_area_q) && $stable(vld_s2))
		else $error("state moved during stall");

endmodule

// ----- tb/sv/monitor_overlap_select_clamp_top_tb.sv -----
// ----------------------------------------------------------------------------
// monitor_overlap_select_clamp_top_tb
// Drives window, second-rect and monitor words into the overlap selector,
// predicts each query result in a scoreboard and checks every result word,
// field by field, under random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module monitor_overlap_select_clamp_top_tb;
	import mosc_pkg::*;

	localparam int HOLD_OFF_CYCLES = 300;
	localparam int DRAIN_LIMIT     = 20000;

	typedef struct packed {
		logic        empty_query;
		logic        pos_mode;
		logic [3:0]  index;
		logic [31:0] area;
		rect_t       mon;
		pos_t        px;
		pos_t        py;
	} choice_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  cmd;
	coord_t      x_low;
	coord_t      y_low;
	coord_t      x_high;
	coord_t      y_high;
	logic        final_monitor;
	logic        out_valid;
	logic        out_ready;
	logic        none_found;
	logic        position_mode;
	logic [3:0]  chosen_index;
	logic [31:0] chosen_area;
	coord_t      mon_left;
	coord_t      mon_top;
	coord_t      mon_right;
	coord_t      mon_bottom;
	pos_t        pos_x;
	pos_t        pos_y;

	int unsigned send_idle_pct;
	int unsigned recv_stall_pct;
	int unsigned words_sent;
	bit          hold_off_req;

	monitor_overlap_select_clamp_top dut (.*);

	class overlap_scoreboard;
		rect_t       window;
		rect_t       second;
		rect_t       best;
		bit          want_pos;
		int unsigned seen;
		int unsigned best_idx;
		logic [31:0] best_area;
		choice_t     pending[$];
		int unsigned mismatches;

		function new();
			window     = '0;
			second     = '0;
			best       = '0;
			want_pos   = 1'b0;
			seen       = 0;
			best_idx   = 0;
			best_area  = '0;
			mismatches = 0;
		endfunction

		// window span clipped by monitor span, floored at zero
		function longint clipped_len(coord_t wlo, coord_t whi, coord_t mlo, coord_t mhi);
			longint len;
			len = longint'(whi) - longint'(wlo);
			if (wlo < mlo)
				len -= longint'(mlo) - longint'(wlo);
			if (whi > mhi)
				len -= longint'(whi) - longint'(mhi);
			return (len < 0) ? 0 : len;
		endfunction

		// high-edge check wins over the low-edge one
		function longint clamp_axis(coord_t lo, coord_t hi, coord_t mlo, coord_t mhi);
			longint p;
			p = lo;
			if (lo < mlo)
				p = mlo;
			if (hi > mhi)
				p = longint'(mhi) - (longint'(hi) - longint'(lo));
			return p;
		endfunction

		function void note_input(logic [1:0] c, rect_t r, logic fin);
			longint      w;
			longint      h;
			longint      prod;
			longint      px;
			longint      py;
			logic [31:0] area;
			int unsigned idx;
			choice_t     want;
			case (c)
				CMD_WINDOW: begin
					window    = r;
					best      = '0;
					want_pos  = 1'b0;
					seen      = 0;
					best_area = '0;
					best_idx  = 0;
				end
				CMD_SECOND: begin
					second   = r;
					want_pos = 1'b1;
				end
				CMD_MONITOR: begin
					w    = clipped_len(window.xl, window.xh, r.xl, r.xh);
					h    = clipped_len(window.yl, window.yh, r.yl, r.yh);
					prod = w * h;
					area = prod[31:0];
					idx  = (seen < MAX_MONITORS - 1) ? seen : MAX_MONITORS - 1;
					if (seen == 0 || area > best_area) begin
						best_area = area;
						best_idx  = idx;
						best      = r;
					end
					if (seen < MAX_MONITORS)
						seen++;
				end
				default: return;
			endcase
			if (!fin)
				return;
			want          = '0;
			want.pos_mode = want_pos;
			if (seen == 0) begin
				want.empty_query = 1'b1;
			end else begin
				px         = clamp_axis(second.xl, second.xh, best.xl, best.xh);
				py         = clamp_axis(second.yl, second.yh, best.yl, best.yh);
				want.index = best_idx[3:0];
				want.area  = best_area;
				want.mon   = best;
				want.px    = px[17:0];
				want.py    = py[17:0];
			end
			pending.insert(pending.size(), want);
		endfunction

		function void check_field(string name, logic [63:0] want, logic [63:0] got);
			if (got !== want) begin
				$error("%s: expected 'h%0h, got 'h%0h", name, want, got);
				mismatches++;
			end
		endfunction

		function void check_result(choice_t got);
			choice_t want;
			if (pending.size() == 0) begin
				$error("result word with nothing pending");
				mismatches++;
				return;
			end
			want = pending.pop_front();
			check_field("none_found", want.empty_query, got.empty_query);
			check_field("position_mode", want.pos_mode, got.pos_mode);
			check_field("chosen_index", want.index, got.index);
			check_field("chosen_area", want.area, got.area);
			check_field("mon_left", want.mon.xl, got.mon.xl);
			check_field("mon_top", want.mon.yl, got.mon.yl);
			check_field("mon_right", want.mon.xh, got.mon.xh);
			check_field("mon_bottom", want.mon.yh, got.mon.yh);
			check_field("pos_x", want.px, got.px);
			check_field("pos_y", want.py, got.py);
		endfunction
	endclass

	overlap_scoreboard sb = new();

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#3000000;
		$display("Mismatches found");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result(choice_t'({none_found, position_mode, chosen_index, chosen_area,
				mon_left, mon_top, mon_right, mon_bottom, pos_x, pos_y}));
		if (arst_n && in_valid && in_ready)
			sb.note_input(cmd, rect_t'({x_low, y_low, x_high, y_high}), final_monitor);
	end

	// receiver: random stalls, plus one long hold-off on request
	initial begin
		bit hold_done;
		hold_done = 1'b0;
		out_ready = 1'b0;
		forever begin
			if (hold_off_req && !hold_done) begin
				hold_done = 1'b1;
				out_ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
			end else begin
				out_ready <= ($urandom_range(99) >= recv_stall_pct);
				@(posedge clk);
			end
		end
	end

	function automatic rect_t mk_rect(int xl, int yl, int xh, int yh);
		return {coord_t'(xl), coord_t'(yl), coord_t'(xh), coord_t'(yh)};
	endfunction

	function automatic coord_t edge_coord();
		case ($urandom_range(4))
			0: return coord_t'(-32768);
			1: return coord_t'(32767);
			2: return coord_t'(-1);
			3: return coord_t'(1);
			default: return coord_t'(0);
		endcase
	endfunction

	function automatic rect_t random_rect();
		rect_t       r;
		int          x0;
		int          y0;
		int unsigned sel;
		sel = $urandom_range(99);
		if (sel < 12) begin
			r = {$urandom, $urandom};
		end else if (sel < 20) begin
			r = {edge_coord(), edge_coord(), edge_coord(), edge_coord()};
		end else begin
			x0   = int'($urandom_range(4000)) - 2000;
			y0   = int'($urandom_range(4000)) - 2000;
			r.xl = coord_t'(x0);
			r.yl = coord_t'(y0);
			// now and then an inverted rect
			if ($urandom_range(19) == 0) begin
				r.xh = coord_t'(x0 - int'($urandom_range(300)));
				r.yh = coord_t'(y0 - int'($urandom_range(300)));
			end else begin
				r.xh = coord_t'(x0 + int'($urandom_range(2500)));
				r.yh = coord_t'(y0 + int'($urandom_range(2500)));
			end
		end
		return r;
	endfunction

	task automatic send_word(logic [1:0] c, rect_t r, logic fin);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid      <= 1'b1;
		cmd           <= c;
		x_low         <= r.xl;
		y_low         <= r.yl;
		x_high        <= r.xh;
		y_high        <= r.yh;
		final_monitor <= fin;
		do
			@(posedge clk);
		while (!in_ready);
		if (c != CMD_UNUSED)
			words_sent++;
	endtask

	task automatic run_query();
		rect_t       win;
		rect_t       r;
		int unsigned n;
		logic        close;
		if ($urandom_range(99) < 8) begin
			send_word(2'($urandom_range(3)), random_rect(), 1'($urandom_range(1)));
			return;
		end
		win = random_rect();
		send_word(CMD_WINDOW, win, $urandom_range(99) < 3);
		if ($urandom_range(99) < 40)
			send_word(CMD_SECOND, random_rect(), $urandom_range(99) < 5);
		n     = ($urandom_range(99) < 15) ? $urandom_range(20, 12) : $urandom_range(6, 1);
		close = ($urandom_range(99) >= 5);
		for (int k = 1; k <= n; k++) begin
			// long queries often end on the window itself so a late index, saturated once n reaches 16, can win
			r = (k == n && n > 12 && $urandom_range(1) == 1) ? win : random_rect();
			send_word(CMD_MONITOR, r, close && k == n);
		end
		if ($urandom_range(99) < 10)
			send_word(CMD_MONITOR, random_rect(), 1'($urandom_range(1)));
		if ($urandom_range(99) < 10)
			send_word(CMD_SECOND, random_rect(), 1'b1);
	endtask

	task automatic run_phase(int unsigned idle_pct, int unsigned stall_pct, int unsigned upto);
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		while (words_sent < upto)
			run_query();
	endtask

	initial begin
		int unsigned waited;
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		cmd            = CMD_WINDOW;
		x_low          = '0;
		y_low          = '0;
		x_high         = '0;
		y_high         = '0;
		final_monitor  = 1'b0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		words_sent     = 0;
		hold_off_req   = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// final with no monitor, rect then position mode; unused cmd is dropped
		send_word(CMD_WINDOW, mk_rect(0, 0, 100, 100), 1'b1);
		send_word(CMD_SECOND, mk_rect(10, 10, 20, 20), 1'b1);
		send_word(CMD_UNUSED, mk_rect(-1, -1, -1, -1), 1'b1);
		// tie keeps the first; larger area then wins; state kept after a result
		send_word(CMD_MONITOR, mk_rect(-50, -50, 50, 50), 1'b0);
		send_word(CMD_MONITOR, mk_rect(0, 0, 50, 50), 1'b0);
		send_word(CMD_MONITOR, mk_rect(50, 0, 200, 200), 1'b1);
		send_word(CMD_MONITOR, mk_rect(-32768, -32768, 32767, 32767), 1'b1);
		send_word(CMD_SECOND, mk_rect(-10, -10, 2000, 2000), 1'b1);
		// full-range window and monitor: largest area
		send_word(CMD_WINDOW, mk_rect(-32768, -32768, 32767, 32767), 1'b0);
		send_word(CMD_MONITOR, mk_rect(-32768, -32768, 32767, 32767), 1'b1);
		// inverted window and inverted monitor give zero overlap
		send_word(CMD_WINDOW, mk_rect(100, 100, 0, 0), 1'b0);
		send_word(CMD_MONITOR, mk_rect(0, 0, 100, 100), 1'b1);
		send_word(CMD_MONITOR, mk_rect(200, 200, 150, 150), 1'b1);
		// clamp where the right/bottom check overrides the left/top one
		send_word(CMD_WINDOW, mk_rect(0, 0, 1000, 1000), 1'b0);
		send_word(CMD_SECOND, mk_rect(-10, -10, 2000, 2000), 1'b0);
		send_word(CMD_MONITOR, mk_rect(0, 0, 1000, 1000), 1'b1);
		send_word(CMD_SECOND, mk_rect(500, 500, 600, 600), 1'b1);
		// most negative clamped position
		send_word(CMD_WINDOW, mk_rect(-32768, -32768, 32767, 32767), 1'b0);
		send_word(CMD_MONITOR, mk_rect(-32768, -32768, -32768, -32768), 1'b0);
		send_word(CMD_SECOND, mk_rect(-32768, -32768, 32767, 32767), 1'b1);
		send_word(CMD_UNUSED, mk_rect(32767, 32767, 32767, 32767), 1'b0);

		// first phase without idling, with a long receiver hold-off up front to back up the pipe; then gaps and stalls
		hold_off_req = 1'b1;
		run_phase(0, 0, words_sent + 130);
		run_phase(53, 0, words_sent + 130);
		run_phase(0, 53, words_sent + 130);
		run_phase(13, 13, words_sent + 130);
		in_valid <= 1'b0;

		waited = 0;
		while (sb.pending.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (10) @(posedge clk);
		if (sb.pending.size() != 0) begin
			$error("%0d result words never arrived", sb.pending.size());
			sb.mismatches++;
		end
		if (sb.mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
